@@ rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int DefCapacity = 64;
  localparam int ValueWidth  = 32;
  localparam int FuncWidth   = 2;
  localparam int StatusWidth = 2;
  localparam int CountWidth  = 7;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // one slot of the sorted row
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         valid;
  } slot_t;

  // commands broadcast from the controller to every cell
  typedef struct packed {
    logic load_flags;
    logic do_insert;
    logic do_remove;
  } cmd_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// Sorted priority queue of signed 32-bit values, largest at the head.
// Request channel: in_valid/in_ready with func and value. func selects
// insert, remove one copy, find, or query only.
// Result channel: out_valid/out_ready with status, count, head_value and
// head_valid; exactly one result per request, in request order.
// Storage is a row of CAPACITY cells; each cell compares its own entry with
// the key and, on insert or remove, shifts from its left or right neighbor,
// so the whole row updates together.
// Sequence: a request is taken in IDLE, the cells latch compare flags in CMP,
// and in UPD the row updates and the result is registered; UPD waits while an
// earlier result is still held. A new request is taken only once UPD has
// returned to IDLE, so the block works on one request at a time.
// The next request may be accepted while a result is still waiting; its
// update holds until the waiting result is taken, so a stalled receiver
// freezes the queue contents but never loses a result.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// Inserts into a full queue are dropped with status full.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DefCapacity
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [spq_pkg::FuncWidth-1:0]          func,
  input  logic signed [spq_pkg::ValueWidth-1:0]  value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [spq_pkg::StatusWidth-1:0]        status,
  output logic [spq_pkg::CountWidth-1:0]         count,
  output logic signed [spq_pkg::ValueWidth-1:0]  head_value,
  output logic                                   head_valid
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t                       state, state_next;
  cmd_t                         cmd;
  func_t                        func_q;
  logic signed [ValueWidth-1:0] key;
  logic [CW-1:0]                cnt;
  status_t                      status_q, status_next;
  logic                         full;
  logic                         found;
  logic                         update;

  slot_t                        slots [CAPACITY];
  logic [CAPACITY-1:0]          gts;
  logic [CAPACITY-1:0]          eqs;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      slot_t prev_s;
      slot_t next_s;
      logic  prev_g;
      if (i == 0) begin : g_first
        assign prev_s = '{value: key, valid: 1'b1};
        assign prev_g = 1'b1;
      end else begin : g_mid
        assign prev_s = slots[i-1];
        assign prev_g = gts[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign next_s = '{value: '0, valid: 1'b0};
      end else begin : g_inner
        assign next_s = slots[i+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .key       (key),
        .prev_slot (prev_s),
        .prev_gt   (prev_g),
        .next_slot (next_s),
        .slot      (slots[i]),
        .gt        (gts[i]),
        .eq        (eqs[i])
      );
    end
  endgenerate

  // row is descending, so any equal entry is the first one not above the key
  assign found = |eqs;
  assign full  = (cnt == CW'(CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    update      = 1'b0;
    status_next = ST_OK;
    unique case (func_q)
      FUNC_INSERT: status_next = full ? ST_FULL : ST_OK;
      FUNC_REMOVE, FUNC_FIND: status_next = found ? ST_OK : ST_ABSENT;
      FUNC_QUERY: status_next = ST_OK;
      default: status_next = ST_OK;
    endcase
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.load_flags = 1'b1;
        state_next     = S_UPD;
      end
      S_UPD: begin
        if (!out_valid || out_ready) begin
          update        = 1'b1;
          cmd.do_insert = (func_q == FUNC_INSERT) && !full;
          cmd.do_remove = (func_q == FUNC_REMOVE) && found;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q <= func_t'(func);
      key    <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (update) begin
        out_valid <= 1'b1;
        if (cmd.do_insert) begin
          cnt <= cnt + 1'b1;
        end else if (cmd.do_remove) begin
          cnt <= cnt - 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      status_q <= status_next;
    end
  end

  assign status     = status_q;
  assign count      = CountWidth'(cnt);
  assign head_valid = slots[0].valid;
  assign head_value = slots[0].valid ? slots[0].value : '0;

endmodule

@@ rtl/spq_cell.sv @@
module spq_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  spq_pkg::cmd_t                          cmd,
  input  logic signed [spq_pkg::ValueWidth-1:0]  key,
  input  spq_pkg::slot_t                         prev_slot,
  input  logic                                   prev_gt,
  input  spq_pkg::slot_t                         next_slot,
  output spq_pkg::slot_t                         slot,
  output logic                                   gt,
  output logic                                   eq
);
  import spq_pkg::*;

  logic signed [ValueWidth-1:0] value;
  logic                         valid;

  assign slot.value = value;
  assign slot.valid = valid;

  // compare flags, taken in CMP ahead of the update
  always_ff @(posedge clk) begin
    if (cmd.load_flags) begin
      gt <= valid && (value > key);
      eq <= valid && (value == key);
    end
  end

  // cells above the insert/remove point keep their data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.do_insert && !gt) begin
      valid <= prev_gt ? 1'b1 : prev_slot.valid;
    end else if (cmd.do_remove && !gt) begin
      valid <= next_slot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert && !gt) begin
      value <= prev_gt ? key : prev_slot.value;
    end else if (cmd.do_remove && !gt) begin
      value <= next_slot.value;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam int Depth      = DefCapacity;
  localparam int CycleLimit = 400000;
  localparam int RandItems  = 1080;

  typedef struct packed {
    func_t                        op;
    logic signed [ValueWidth-1:0] operand;
  } req_t;

  typedef struct packed {
    status_t                      status;
    logic [CountWidth-1:0]        count;
    logic signed [ValueWidth-1:0] head_value;
    logic                         head_valid;
  } result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [FuncWidth-1:0]         func = '0;
  logic signed [ValueWidth-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [StatusWidth-1:0]       status;
  logic [CountWidth-1:0]        count;
  logic signed [ValueWidth-1:0] head_value;
  logic                         head_valid;

  sorted_priority_queue #(.CAPACITY(Depth)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .head_value(head_value),
    .head_valid(head_valid)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the queue, descending from index 0
  logic signed [ValueWidth-1:0] held_vals [Depth];
  int                           held_cnt = 0;

  req_t    req_backlog[$];
  result_t want_results[$];
  logic signed [ValueWidth-1:0] recent_vals[$];

  int   mismatches = 0;
  int   cycles = 0;
  int   taken_reqs = 0;
  logic req_taken = 1'b0;
  logic gen_done = 1'b0;

  task automatic apply_request(input func_t op, input logic signed [ValueWidth-1:0] key);
    result_t r;
    int      pos;
    r.status = ST_OK;
    pos = 0;
    while (pos < held_cnt && held_vals[pos] > key) pos++;
    case (op)
      FUNC_INSERT: begin
        if (held_cnt >= Depth) begin
          r.status = ST_FULL;
        end else begin
          for (int k = held_cnt; k > pos; k--) held_vals[k] = held_vals[k-1];
          held_vals[pos] = key;
          held_cnt++;
        end
      end
      FUNC_REMOVE, FUNC_FIND: begin
        if (pos < held_cnt && held_vals[pos] == key) begin
          if (op == FUNC_REMOVE) begin
            for (int k = pos; k < held_cnt - 1; k++) held_vals[k] = held_vals[k+1];
            held_cnt--;
          end
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
    r.count = CountWidth'(held_cnt);
    r.head_valid = (held_cnt > 0);
    r.head_value = (held_cnt > 0) ? held_vals[0] : '0;
    want_results.push_back(r);
  endtask

  task automatic add_req(input func_t op, input logic signed [ValueWidth-1:0] v);
    req_t q;
    q.op = op;
    q.operand = v;
    req_backlog.push_back(q);
    if (op == FUNC_INSERT) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > Depth) void'(recent_vals.pop_front());
    end
  endtask

  function automatic logic signed [ValueWidth-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $signed(ValueWidth'($urandom_range(0, 6))) - 3;
    if (r < 35) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  // removes and finds mostly aim at values that were inserted lately
  function automatic logic signed [ValueWidth-1:0] pick_target(input logic consume);
    int idx;
    logic signed [ValueWidth-1:0] v;
    if (recent_vals.size() > 0 && $urandom_range(0, 99) < 65) begin
      idx = $urandom_range(0, recent_vals.size() - 1);
      v = recent_vals[idx];
      if (consume) recent_vals.delete(idx);
      return v;
    end
    return pick_value();
  endfunction

  initial begin : stimulus
    int made;
    int seg;
    int seg_len;
    int r;
    made = 0;
    seg = 0;
    // empty queue cases
    add_req(FUNC_QUERY, 32'sd0);
    add_req(FUNC_FIND, 32'sd5);
    add_req(FUNC_REMOVE, 32'sd5);
    // extremes, duplicates, hits and misses
    add_req(FUNC_INSERT, 32'sh80000000);
    add_req(FUNC_INSERT, 32'sh7fffffff);
    add_req(FUNC_INSERT, 32'sd0);
    add_req(FUNC_INSERT, 32'sd0);
    add_req(FUNC_INSERT, -32'sd1);
    add_req(FUNC_FIND, 32'sd0);
    add_req(FUNC_FIND, 32'sd7);
    add_req(FUNC_REMOVE, 32'sd0);
    add_req(FUNC_FIND, 32'sd0);
    add_req(FUNC_REMOVE, 32'sd0);
    add_req(FUNC_FIND, 32'sd0);
    add_req(FUNC_REMOVE, 32'sd123);
    add_req(FUNC_REMOVE, 32'sh7fffffff);
    add_req(FUNC_REMOVE, 32'sh80000000);
    add_req(FUNC_REMOVE, -32'sd1);
    add_req(FUNC_QUERY, 32'sh7fffffff);
    add_req(FUNC_INSERT, 32'sh55555555);
    add_req(FUNC_INSERT, 32'shaaaaaaaa);
    add_req(FUNC_QUERY, -32'sd1);
    recent_vals.delete();

    // segments: fill up past full, drain, then mix
    while (made < RandItems) begin
      seg_len = (seg % 3 == 1) ? $urandom_range(120, 200) : $urandom_range(90, 150);
      for (int i = 0; i < seg_len && made < RandItems; i++) begin
        r = $urandom_range(0, 99);
        case (seg % 3)
          0: begin
            if (r < 88)      add_req(FUNC_INSERT, pick_value());
            else if (r < 93) add_req(FUNC_FIND, pick_target(1'b0));
            else if (r < 97) add_req(FUNC_REMOVE, pick_target(1'b1));
            else             add_req(FUNC_QUERY, $signed($urandom));
          end
          1: begin
            if (r < 80)      add_req(FUNC_REMOVE, pick_target(1'b1));
            else if (r < 92) add_req(FUNC_FIND, pick_target(1'b0));
            else if (r < 96) add_req(FUNC_INSERT, pick_value());
            else             add_req(FUNC_QUERY, $signed($urandom));
          end
          default: begin
            if (r < 30)      add_req(FUNC_INSERT, pick_value());
            else if (r < 60) add_req(FUNC_REMOVE, pick_target(1'b1));
            else if (r < 90) add_req(FUNC_FIND, pick_target(1'b0));
            else             add_req(FUNC_QUERY, $signed($urandom));
          end
        endcase
        made++;
      end
      seg++;
    end
    gen_done = 1'b1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(req_backlog.size() == 0 && !in_valid && want_results.size() == 0))
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_priority_queue test passed");
    end else begin
      $display("sorted_priority_queue test failed");
    end
    $finish;
  end

  // request driver: bursts with random gaps
  int   burst_left = 0;
  int   gap_left = 0;
  req_t next_req;

  always @(negedge clk) begin
    if (rst || !gen_done) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (req_backlog.size() > 0) begin
      next_req = req_backlog.pop_front();
      func     <= next_req.op;
      value    <= next_req.operand;
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 4) == 0) begin
        gap_left   = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        gap_left   = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 30);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: stall pattern of its own plus one long hold-off
  int   rx_mode = 0;
  int   rx_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && taken_reqs >= 400) begin
        hold_done = 1'b1;
        hold_left = 500;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // monitor: check results, then predict for the request taken at this edge
  result_t got;
  result_t exp_r;

  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      cycles++;
      if (out_valid && out_ready) begin
        got.status     = status_t'(status);
        got.count      = count;
        got.head_value = head_value;
        got.head_valid = head_valid;
        if (want_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status=%0d count=%0d head=%0d valid=%0b",
                   $time, got.status, got.count, got.head_value, got.head_valid);
        end else begin
          exp_r = want_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            $display("%0t: mismatch exp status=%0d count=%0d head=%0d valid=%0b",
                     $time, exp_r.status, exp_r.count, exp_r.head_value, exp_r.head_valid);
            $display("%0t:          got status=%0d count=%0d head=%0d valid=%0b",
                     $time, got.status, got.count, got.head_value, got.head_valid);
          end
        end
      end
      if (in_valid && in_ready) begin
        req_taken = 1'b1;
        taken_reqs++;
        apply_request(func_t'(func), value);
      end
      if (cycles > CycleLimit) begin
        $display("sorted_priority_queue test failed");
        $finish;
      end
    end
  end

endmodule
